// File: design/ntq_pkg.sv
package ntq_pkg;

    localparam int TIME_BITS   = 48;
    localparam int OFFSET_BITS = 16;
    localparam int LEN_BITS    = OFFSET_BITS + 1;
    localparam int GRID_W      = 32;
    localparam int HALF_W      = GRID_W - 1;
    localparam int DEN_W       = 21;
    localparam int XW          = TIME_BITS + 2;
    localparam int DIFF_W      = GRID_W + 2;
    localparam int MAG_W       = GRID_W + 1;
    localparam int POS_W       = MAG_W + 2;
    localparam int SR_W        = 18;
    localparam int TEMPO_W     = 18;
    localparam int DIVC_W      = 3;
    localparam int Q8_W        = 9;

    localparam logic [2:0] REG_SAMPLE_RATE = 3'd0;
    localparam logic [2:0] REG_TEMPO       = 3'd1;
    localparam logic [2:0] REG_GRID_DIV    = 3'd2;
    localparam logic [2:0] REG_SWING       = 3'd3;
    localparam logic [2:0] REG_STRENGTH    = 3'd4;

    localparam logic [1:0] PL_INSIDE = 2'd0;
    localparam logic [1:0] PL_END    = 2'd1;
    localparam logic [1:0] PL_START  = 2'd2;
    localparam logic [1:0] PL_PASS   = 2'd3;

    typedef struct packed {
        logic                   tempo_known;
        logic                   is_note;
        logic [TIME_BITS-1:0]   block_start;
        logic [OFFSET_BITS-1:0] event_offset;
        logic [LEN_BITS-1:0]    block_length;
    } t_req;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] new_offset;
        logic [1:0]             placement;
    } t_rsp;

    // classified request, queued between front and back
    typedef struct packed {
        logic                   pass;
        logic [XW-1:0]          x;
        logic [OFFSET_BITS-1:0] offset;
        logic [LEN_BITS-1:0]    length;
    } t_job;

    typedef struct packed {
        logic [GRID_W-1:0] grid;
        logic [HALF_W-1:0] half;
        logic [GRID_W-1:0] swing_amt;
        logic              zero;
        logic [Q8_W-1:0]   strength;
    } t_grid;

    function automatic logic [3:0] grid_div(input logic [DIVC_W-1:0] code);
        logic [3:0] d;
        unique case (code)
            3'd1:    d = 4'd2;
            3'd2:    d = 4'd4;
            3'd3:    d = 4'd8;
            3'd4:    d = 4'd3;
            3'd5:    d = 4'd6;
            default: d = 4'd1;
        endcase
        return d;
    endfunction

endpackage

// File: design/note_timing_quantizer.sv
// Note timing quantizer. Takes one event request per cycle while busy is low and
// returns its result on o_rsp, marked by o_done for one cycle; results come out in
// request order and cannot be held off. The result path runs through the snap
// divider, a pipeline with one stage per dividend bit. After reset and after every
// register write, busy stays high while a serial divider recomputes the grid size,
// one bit a cycle.
module note_timing_quantizer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ntq_pkg::t_req i_req,
    output logic          o_done,
    output ntq_pkg::t_rsp o_rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    logic           cfg_busy;
    ntq_pkg::t_grid grid;
    logic           q_full;
    logic           push;
    logic           pop;
    ntq_pkg::t_job  f_job;
    ntq_pkg::t_job  q_job;

    assign pready = 1'b1;

    ntq_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_busy  (cfg_busy),
        .o_grid  (grid)
    );

    ntq_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req      (i_req),
        .i_cfg_busy (cfg_busy),
        .i_q_full   (q_full),
        .i_grid     (grid),
        .o_busy     (busy),
        .o_push     (push),
        .o_job      (f_job)
    );

    ntq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_pop   (pop),
        .o_job   (q_job)
    );

    ntq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (pop),
        .i_job   (q_job),
        .i_grid  (grid),
        .o_done  (o_done),
        .o_rsp   (o_rsp)
    );

    a_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        psel && penable && pwrite |=> busy)
        else $error("register write did not start grid recompute");

    a_start_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_rsp.placement == ntq_pkg::PL_START |-> o_rsp.new_offset == '0)
        else $error("start clamp with nonzero offset");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_full |-> !pop == 1'b0)
        else $error("queue full but not draining");

endmodule

// File: design/ntq_cfg.sv
module ntq_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [4:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 o_busy,
    output ntq_pkg::t_grid       o_grid
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_SWING = 2'd3;

    logic [ntq_pkg::SR_W-1:0]    r_sr;
    logic [ntq_pkg::TEMPO_W-1:0] r_tempo;
    logic [ntq_pkg::DIVC_W-1:0]  r_divc;
    logic [ntq_pkg::Q8_W-1:0]    r_swing;
    logic [ntq_pkg::Q8_W-1:0]    r_strength;

    logic [1:0]                  r_state;
    logic [4:0]                  r_cnt;
    logic [ntq_pkg::GRID_W-1:0]  r_num;
    logic [ntq_pkg::DEN_W-1:0]   r_den;
    logic [ntq_pkg::DEN_W-1:0]   r_rem;
    ntq_pkg::t_grid              r_grid;

    logic                        wr;
    logic [ntq_pkg::DEN_W:0]     trial;
    logic                        ge;
    logic [3:0]                  divisor;
    logic [ntq_pkg::GRID_W+ntq_pkg::Q8_W-1:0] sw_prod;

    assign wr      = psel && penable && pwrite;
    assign trial   = {r_rem, r_num[ntq_pkg::GRID_W-1]};
    assign ge      = trial >= {1'b0, r_den};
    assign divisor = ntq_pkg::grid_div(r_divc);
    assign sw_prod = r_num * r_swing;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sr       <= 18'd48000;
            r_tempo    <= 18'd30720;
            r_divc     <= 3'd2;
            r_swing    <= 9'd0;
            r_strength <= 9'd256;
        end else if (wr) begin
            unique case (paddr[4:2])
                ntq_pkg::REG_SAMPLE_RATE: r_sr       <= pwdata[ntq_pkg::SR_W-1:0];
                ntq_pkg::REG_TEMPO:       r_tempo    <= pwdata[ntq_pkg::TEMPO_W-1:0];
                ntq_pkg::REG_GRID_DIV:    r_divc     <= pwdata[ntq_pkg::DIVC_W-1:0];
                ntq_pkg::REG_SWING:       r_swing    <= pwdata[ntq_pkg::Q8_W-1:0];
                ntq_pkg::REG_STRENGTH:    r_strength <= pwdata[ntq_pkg::Q8_W-1:0];
                default: ;
            endcase
        end
    end

    // grid = sample_rate*15360 / (tempo*div), one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
        end else if (wr) begin
            r_state <= ST_LOAD;
        end else begin
            unique case (r_state)
                ST_LOAD: begin
                    r_state <= ST_DIV;
                    r_cnt   <= '0;
                end
                ST_DIV: begin
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd31) begin
                        r_state <= ST_SWING;
                    end
                end
                ST_SWING: r_state <= ST_IDLE;
                default:  r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_LOAD: begin
                r_num <= {14'd0, r_sr} * 32'd15360;
                r_den <= {3'd0, r_tempo} * {17'd0, divisor};
                r_rem <= '0;
            end
            ST_DIV: begin
                r_rem <= ge ? ntq_pkg::DEN_W'(trial - {1'b0, r_den})
                            : trial[ntq_pkg::DEN_W-1:0];
                r_num <= {r_num[ntq_pkg::GRID_W-2:0], ge};
            end
            ST_SWING: begin
                r_grid.grid      <= r_num;
                r_grid.half      <= r_num[ntq_pkg::GRID_W-1:1];
                r_grid.swing_amt <= sw_prod[ntq_pkg::GRID_W+8:9];
                r_grid.zero      <= (r_tempo == '0) || (r_num == '0);
            end
            default: ;
        endcase
        r_grid.strength <= r_strength;
    end

    always_comb begin
        case (paddr[4:2])
            ntq_pkg::REG_SAMPLE_RATE: prdata = 32'(r_sr);
            ntq_pkg::REG_TEMPO:       prdata = 32'(r_tempo);
            ntq_pkg::REG_GRID_DIV:    prdata = 32'(r_divc);
            ntq_pkg::REG_SWING:       prdata = 32'(r_swing);
            ntq_pkg::REG_STRENGTH:    prdata = 32'(r_strength);
            default:                  prdata = '0;
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_grid = r_grid;

endmodule

// File: design/ntq_front.sv
module ntq_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ntq_pkg::t_req  i_req,
    input  logic           i_cfg_busy,
    input  logic           i_q_full,
    input  ntq_pkg::t_grid i_grid,
    output logic           o_busy,
    output logic           o_push,
    output ntq_pkg::t_job  o_job
);

    logic          r_valid;
    ntq_pkg::t_job r_job;
    logic          accept;

    assign o_busy = i_cfg_busy || (r_valid && i_q_full);
    assign accept = i_start && !o_busy;
    assign o_push = r_valid && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    // add half a grid so the divide rounds to the nearest line
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_job.pass   <= !i_req.tempo_known || !i_req.is_note || i_grid.zero;
            r_job.x      <= ntq_pkg::XW'(i_req.block_start) + ntq_pkg::XW'(i_req.event_offset)
                            + ntq_pkg::XW'(i_grid.half);
            r_job.offset <= i_req.event_offset;
            r_job.length <= i_req.block_length;
        end
    end

    assign o_job = r_job;

endmodule

// File: design/ntq_queue.sv
module ntq_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ntq_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_pop,
    output ntq_pkg::t_job o_job
);

    ntq_pkg::t_job r_mem [0:1];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    // the back end never stalls: drain whenever not empty
    assign o_pop  = (r_cnt != 2'd0);
    assign o_full = (r_cnt == 2'd2);
    assign o_job  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (o_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(o_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// File: design/ntq_back.sv
module ntq_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  ntq_pkg::t_job  i_job,
    input  ntq_pkg::t_grid i_grid,
    output logic           o_done,
    output ntq_pkg::t_rsp  o_rsp
);

    localparam int XW = ntq_pkg::XW;
    localparam int GW = ntq_pkg::GRID_W;
    localparam int OB = ntq_pkg::OFFSET_BITS;
    localparam int LB = ntq_pkg::LEN_BITS;

    logic                   r_v    [0:XW];
    logic [GW-1:0]          r_rem  [0:XW];
    logic [XW-1:0]          r_x    [0:XW];
    logic                   r_pass [0:XW];
    logic [OB-1:0]          r_off  [0:XW];
    logic [LB-1:0]          r_len  [0:XW];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem[0]  <= '0;
        r_x[0]    <= i_job.x;
        r_pass[0] <= i_job.pass;
        r_off[0]  <= i_job.offset;
        r_len[0]  <= i_job.length;
    end

    // restoring divide by grid, one dividend bit per stage
    for (genvar g = 0; g < XW; g++) begin : g_div
        logic [GW:0] trial;
        logic        ge;
        assign trial = {r_rem[g], r_x[g][XW-1]};
        assign ge    = trial >= {1'b0, i_grid.grid};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else begin
                r_v[g+1] <= r_v[g];
            end
        end

        always_ff @(posedge i_clk) begin
            r_rem[g+1]  <= ge ? GW'(trial - {1'b0, i_grid.grid}) : trial[GW-1:0];
            r_x[g+1]    <= {r_x[g][XW-2:0], ge};
            r_pass[g+1] <= r_pass[g];
            r_off[g+1]  <= r_off[g];
            r_len[g+1]  <= r_len[g];
        end
    end

    // snapped - abs = half - remainder, plus swing on odd lines
    logic [ntq_pkg::DIFF_W-1:0] diff;
    logic                       r_a_v, r_a_pass, r_a_neg;
    logic [ntq_pkg::MAG_W-1:0]  r_a_mag;
    logic [OB-1:0]              r_a_off;
    logic [LB-1:0]              r_a_len;

    assign diff = ntq_pkg::DIFF_W'(i_grid.half)
                + (r_x[XW][0] ? ntq_pkg::DIFF_W'(i_grid.swing_amt) : '0)
                - ntq_pkg::DIFF_W'(r_rem[XW]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
        end else begin
            r_a_v <= r_v[XW];
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_neg  <= diff[ntq_pkg::DIFF_W-1];
        r_a_mag  <= diff[ntq_pkg::DIFF_W-1] ? ntq_pkg::MAG_W'(-diff)
                                            : diff[ntq_pkg::MAG_W-1:0];
        r_a_pass <= r_pass[XW];
        r_a_off  <= r_off[XW];
        r_a_len  <= r_len[XW];
    end

    // scale the move by strength, truncating toward zero
    logic [ntq_pkg::MAG_W+ntq_pkg::Q8_W-1:0] prod;
    logic                      r_b_v, r_b_pass, r_b_neg;
    logic [ntq_pkg::MAG_W-1:0] r_b_mag;
    logic [OB-1:0]             r_b_off;
    logic [LB-1:0]             r_b_len;

    assign prod = r_a_mag * i_grid.strength;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_v <= 1'b0;
        end else begin
            r_b_v <= r_a_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_neg  <= r_a_neg;
        r_b_mag  <= i_grid.strength[ntq_pkg::Q8_W-1] ? r_a_mag
                                                      : prod[ntq_pkg::MAG_W+7:8];
        r_b_pass <= r_a_pass;
        r_b_off  <= r_a_off;
        r_b_len  <= r_a_len;
    end

    // place inside the block, clamp to its edges; pass jobs keep their offset
    logic [ntq_pkg::POS_W-1:0] pos;
    logic [LB-1:0]             lim;
    logic                      r_done;
    ntq_pkg::t_rsp             r_rsp;

    assign pos = r_b_neg ? ntq_pkg::POS_W'(r_b_off) - ntq_pkg::POS_W'(r_b_mag)
                         : ntq_pkg::POS_W'(r_b_off) + ntq_pkg::POS_W'(r_b_mag);

    always_comb begin
        if (r_b_len == '0) begin
            lim = LB'(1);
        end else if (r_b_len > (LB'(1) << OB)) begin
            lim = LB'(1) << OB;
        end else begin
            lim = r_b_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_b_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_pass) begin
            r_rsp.new_offset <= r_b_off;
            r_rsp.placement  <= ntq_pkg::PL_PASS;
        end else if (pos[ntq_pkg::POS_W-1]) begin
            r_rsp.new_offset <= '0;
            r_rsp.placement  <= ntq_pkg::PL_START;
        end else if (pos >= ntq_pkg::POS_W'(lim)) begin
            r_rsp.new_offset <= OB'(lim - LB'(1));
            r_rsp.placement  <= ntq_pkg::PL_END;
        end else begin
            r_rsp.new_offset <= pos[OB-1:0];
            r_rsp.placement  <= ntq_pkg::PL_INSIDE;
        end
    end

    assign o_done = r_done;
    assign o_rsp  = r_rsp;

endmodule
